### design/spmd_pkg.sv
// Package for the segment pair minimum distance block.
// Holds the coordinate and result widths and the derived datapath widths.
// No dependencies.
`default_nettype none

package spmd_pkg;

   localparam int COORD_BITS = 11;
   localparam int FRAC_BITS  = 4;
   localparam int GAP_BITS   = 16;
   localparam int LANES      = 4;

   // Signed coordinate difference.
   localparam int DIFF_W = COORD_BITS + 1;
   // Signed cross and dot products.
   localparam int CR_W   = 2 * DIFF_W + 1;
   // Squared lengths and the magnitude of a cross product.
   localparam int DEN_W  = 2 * COORD_BITS + 1;
   localparam int NUM_W  = 2 * DEN_W;
   localparam int TGT_W  = NUM_W + 2 * FRAC_BITS;
   localparam int ACC_W  = 2 * GAP_BITS + DEN_W;
   localparam int CMP_W  = ((TGT_W > ACC_W) ? TGT_W : ACC_W) + 1;

endpackage

`default_nettype wire

### design/segment_pair_min_distance.sv
// Shortest distance between two 2-D integer segments, with a meet flag.
// A request word passes through the difference, product, selection, root and output registers.
// Throughput: one word per cycle; the whole pipeline advances unless the
// output holds an untaken word, so a stall on rsp_ backs up to req_stall.
// The 16-stage square root, one result bit per stage, sets the depth.
// Reset is synchronous and active high and clears all valid bits.
`default_nettype none

module segment_pair_min_distance
   import spmd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [COORD_BITS-1:0] req_first_start_x,
   input  wire logic [COORD_BITS-1:0] req_first_start_y,
   input  wire logic [COORD_BITS-1:0] req_first_end_x,
   input  wire logic [COORD_BITS-1:0] req_first_end_y,
   input  wire logic [COORD_BITS-1:0] req_second_start_x,
   input  wire logic [COORD_BITS-1:0] req_second_start_y,
   input  wire logic [COORD_BITS-1:0] req_second_end_x,
   input  wire logic [COORD_BITS-1:0] req_second_end_y,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [GAP_BITS-1:0]        rsp_gap_length,
   output logic                       rsp_segments_meet
);

   localparam int RS = GAP_BITS;

   logic adv;
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   // Lane k measures point p against segment a-b.
   logic [COORD_BITS-1:0] ax [LANES];
   logic [COORD_BITS-1:0] ay [LANES];
   logic [COORD_BITS-1:0] bx [LANES];
   logic [COORD_BITS-1:0] by [LANES];
   logic [COORD_BITS-1:0] px [LANES];
   logic [COORD_BITS-1:0] py [LANES];

   always_comb begin
      ax[0] = req_first_start_x;  ay[0] = req_first_start_y;
      bx[0] = req_first_end_x;    by[0] = req_first_end_y;
      px[0] = req_second_start_x; py[0] = req_second_start_y;
      ax[1] = req_first_start_x;  ay[1] = req_first_start_y;
      bx[1] = req_first_end_x;    by[1] = req_first_end_y;
      px[1] = req_second_end_x;   py[1] = req_second_end_y;
      ax[2] = req_second_start_x; ay[2] = req_second_start_y;
      bx[2] = req_second_end_x;   by[2] = req_second_end_y;
      px[2] = req_first_start_x;  py[2] = req_first_start_y;
      ax[3] = req_second_start_x; ay[3] = req_second_start_y;
      bx[3] = req_second_end_x;   by[3] = req_second_end_y;
      px[3] = req_first_end_x;    py[3] = req_first_end_y;
   end

   // Stage 1: coordinate differences.
   logic                     v1_ff;
   logic signed [DIFF_W-1:0] abx_ff [LANES];
   logic signed [DIFF_W-1:0] aby_ff [LANES];
   logic signed [DIFF_W-1:0] apx_ff [LANES];
   logic signed [DIFF_W-1:0] apy_ff [LANES];
   logic signed [DIFF_W-1:0] bpx_ff [LANES];
   logic signed [DIFF_W-1:0] bpy_ff [LANES];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_valid;
      end
      if (adv) begin
         for (int k = 0; k < LANES; k++) begin
            abx_ff[k] <= $signed({1'b0, bx[k]}) - $signed({1'b0, ax[k]});
            aby_ff[k] <= $signed({1'b0, by[k]}) - $signed({1'b0, ay[k]});
            apx_ff[k] <= $signed({1'b0, px[k]}) - $signed({1'b0, ax[k]});
            apy_ff[k] <= $signed({1'b0, py[k]}) - $signed({1'b0, ay[k]});
            bpx_ff[k] <= $signed({1'b0, px[k]}) - $signed({1'b0, bx[k]});
            bpy_ff[k] <= $signed({1'b0, py[k]}) - $signed({1'b0, by[k]});
         end
      end
   end

   // Stage 2: cross, dot and squared lengths.
   logic                   v2_ff;
   logic signed [CR_W-1:0] cr_ff   [LANES];
   logic signed [CR_W-1:0] dt_ff   [LANES];
   logic [DEN_W-1:0]       len_ff  [LANES];
   logic [DEN_W-1:0]       sqap_ff [LANES];
   logic [DEN_W-1:0]       sqbp_ff [LANES];
   logic signed [CR_W-1:0] len_full  [LANES];
   logic signed [CR_W-1:0] sqap_full [LANES];
   logic signed [CR_W-1:0] sqbp_full [LANES];

   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         len_full[k]  = CR_W'(abx_ff[k]) * CR_W'(abx_ff[k])
                      + CR_W'(aby_ff[k]) * CR_W'(aby_ff[k]);
         sqap_full[k] = CR_W'(apx_ff[k]) * CR_W'(apx_ff[k])
                      + CR_W'(apy_ff[k]) * CR_W'(apy_ff[k]);
         sqbp_full[k] = CR_W'(bpx_ff[k]) * CR_W'(bpx_ff[k])
                      + CR_W'(bpy_ff[k]) * CR_W'(bpy_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
      if (adv) begin
         for (int k = 0; k < LANES; k++) begin
            cr_ff[k]   <= CR_W'(abx_ff[k]) * CR_W'(apy_ff[k])
                        - CR_W'(aby_ff[k]) * CR_W'(apx_ff[k]);
            dt_ff[k]   <= CR_W'(abx_ff[k]) * CR_W'(apx_ff[k])
                        + CR_W'(aby_ff[k]) * CR_W'(apy_ff[k]);
            len_ff[k]  <= len_full[k][DEN_W-1:0];
            sqap_ff[k] <= sqap_full[k][DEN_W-1:0];
            sqbp_ff[k] <= sqbp_full[k][DEN_W-1:0];
         end
      end
   end

   // Stage 3: orientation codes, meet test and choice of distance form.
   logic                   v3_ff;
   logic                   meet3_ff;
   logic                   iscr3_ff [LANES];
   logic [DEN_W-1:0]       num3_ff  [LANES];
   logic [DEN_W-1:0]       den3_ff  [LANES];
   logic                   code_zero [LANES];
   logic                   code_neg  [LANES];
   logic                   sel_cr    [LANES];
   logic [DEN_W-1:0]       sel_num   [LANES];
   logic [DEN_W-1:0]       sel_den   [LANES];
   logic signed [CR_W-1:0] len_s     [LANES];
   logic [CR_W-1:0]        cr_mag    [LANES];
   logic                   meet_c;

   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         len_s[k]     = $signed(CR_W'(len_ff[k]));
         cr_mag[k]    = (cr_ff[k] < 0) ? CR_W'(-cr_ff[k]) : CR_W'(cr_ff[k]);
         // A collinear point is negative before the start and zero on the segment.
         code_neg[k]  = (cr_ff[k] < 0) || ((cr_ff[k] == 0) && (dt_ff[k] < 0));
         code_zero[k] = (cr_ff[k] == 0) && (dt_ff[k] >= 0) && (len_ff[k] >= sqap_ff[k]);
         sel_cr[k]    = 1'b0;
         sel_den[k]   = DEN_W'(1);
         if (len_ff[k] == '0 || dt_ff[k] <= 0) begin
            sel_num[k] = sqap_ff[k];
         end else if (dt_ff[k] >= len_s[k]) begin
            sel_num[k] = sqbp_ff[k];
         end else begin
            sel_cr[k]  = 1'b1;
            sel_num[k] = cr_mag[k][DEN_W-1:0];
            sel_den[k] = len_ff[k];
         end
      end
      meet_c = (code_zero[0] || code_zero[1] || (code_neg[0] != code_neg[1])) &&
               (code_zero[2] || code_zero[3] || (code_neg[2] != code_neg[3]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= v2_ff;
      end
      if (adv) begin
         meet3_ff <= meet_c;
         for (int k = 0; k < LANES; k++) begin
            iscr3_ff[k] <= sel_cr[k];
            num3_ff[k]  <= sel_num[k];
            den3_ff[k]  <= sel_den[k];
         end
      end
   end

   // Root pipeline: stage i decides result bit GAP_BITS-1-i, keeping
   // p = y*y*den and q = y*den so each step needs only adds and a compare.
   logic             rt_v_ff    [RS+1];
   logic             rt_meet_ff [RS+1];
   logic [GAP_BITS-1:0] rt_y_ff [RS+1][LANES];
   logic [CMP_W-1:0] rt_p_ff    [RS+1][LANES];
   logic [CMP_W-1:0] rt_q_ff    [RS+1][LANES];
   logic [CMP_W-1:0] rt_t_ff    [RS+1][LANES];
   logic [CMP_W-1:0] rt_d_ff    [RS+1][LANES];
   logic [NUM_W-1:0] sq_num     [LANES];

   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         sq_num[k] = iscr3_ff[k] ? NUM_W'(num3_ff[k]) * NUM_W'(num3_ff[k])
                                 : NUM_W'(num3_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rt_v_ff[0] <= 1'b0;
      end else if (adv) begin
         rt_v_ff[0] <= v3_ff;
      end
      if (adv) begin
         rt_meet_ff[0] <= meet3_ff;
         for (int k = 0; k < LANES; k++) begin
            rt_y_ff[0][k] <= '0;
            rt_p_ff[0][k] <= '0;
            rt_q_ff[0][k] <= '0;
            rt_t_ff[0][k] <= CMP_W'(sq_num[k]) << (2 * FRAC_BITS);
            rt_d_ff[0][k] <= CMP_W'(den3_ff[k]);
         end
      end
   end

   for (genvar i = 0; i < RS; i++) begin : g_root
      localparam int B = GAP_BITS - 1 - i;
      logic [CMP_W-1:0] cand [LANES];
      logic             take [LANES];

      always_comb begin
         for (int k = 0; k < LANES; k++) begin
            cand[k] = rt_p_ff[i][k] + (rt_q_ff[i][k] << (B + 1))
                    + (rt_d_ff[i][k] << (2 * B));
            take[k] = (cand[k] <= rt_t_ff[i][k]);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            rt_v_ff[i+1] <= 1'b0;
         end else if (adv) begin
            rt_v_ff[i+1] <= rt_v_ff[i];
         end
         if (adv) begin
            rt_meet_ff[i+1] <= rt_meet_ff[i];
            for (int k = 0; k < LANES; k++) begin
               rt_t_ff[i+1][k] <= rt_t_ff[i][k];
               rt_d_ff[i+1][k] <= rt_d_ff[i][k];
               if (take[k]) begin
                  rt_y_ff[i+1][k] <= rt_y_ff[i][k] | (GAP_BITS'(1) << B);
                  rt_p_ff[i+1][k] <= cand[k];
                  rt_q_ff[i+1][k] <= rt_q_ff[i][k] + (rt_d_ff[i][k] << B);
               end else begin
                  rt_y_ff[i+1][k] <= rt_y_ff[i][k];
                  rt_p_ff[i+1][k] <= rt_p_ff[i][k];
                  rt_q_ff[i+1][k] <= rt_q_ff[i][k];
               end
            end
         end
      end
   end

   // Output stage: least of the four lane distances, or zero when the segments meet.
   logic                out_v_ff;
   logic                out_meet_ff;
   logic [GAP_BITS-1:0] out_gap_ff;
   logic [GAP_BITS-1:0] min01;
   logic [GAP_BITS-1:0] min23;
   logic [GAP_BITS-1:0] min_all;

   always_comb begin
      min01   = (rt_y_ff[RS][1] < rt_y_ff[RS][0]) ? rt_y_ff[RS][1] : rt_y_ff[RS][0];
      min23   = (rt_y_ff[RS][3] < rt_y_ff[RS][2]) ? rt_y_ff[RS][3] : rt_y_ff[RS][2];
      min_all = (min23 < min01) ? min23 : min01;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (adv) begin
         out_v_ff <= rt_v_ff[RS];
      end
      if (adv) begin
         out_meet_ff <= rt_meet_ff[RS];
         out_gap_ff  <= rt_meet_ff[RS] ? '0 : min_all;
      end
   end

   assign rsp_valid         = out_v_ff;
   assign rsp_gap_length    = out_gap_ff;
   assign rsp_segments_meet = out_meet_ff;

   a_meet_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_segments_meet |-> rsp_gap_length == '0)
      else $error("meeting segments reported a nonzero gap");

   a_den_nonzero : assert property (@(posedge clock) disable iff (reset)
      rt_v_ff[0] |-> rt_d_ff[0][0] != '0 && rt_d_ff[0][1] != '0 &&
                     rt_d_ff[0][2] != '0 && rt_d_ff[0][3] != '0)
      else $error("root stage entered with a zero denominator");

   a_root_bound : assert property (@(posedge clock) disable iff (reset)
      rt_v_ff[RS] |-> rt_p_ff[RS][0] <= rt_t_ff[RS][0] &&
                      rt_p_ff[RS][3] <= rt_t_ff[RS][3])
      else $error("root result squared exceeds its target");

endmodule

`default_nettype wire
